// File: src/gfba_pkg.sv
`default_nettype none
package gfba_pkg;

   // Fixed field widths of the channels
   localparam int BLOCK_W  = 10;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam int DEF_GROUP_SIZE   = 16;
   localparam int DEF_TOTAL_BLOCKS = 1024;
   localparam int DEF_MAX_RUN      = 16;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_OCC  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef struct packed {
      logic                init_step;
      logic                take;
      logic                rel_free;
      logic                rel_push;
      logic                base_ld;
      logic                base_src;   // 0: released block, 1: cache entry
      logic                copy_step;
      logic                copy_fin;
      logic                pop;
      logic                load_step;
      logic                res_ld;
      logic [STATUS_W-1:0] res_status;
      logic                emit;
   } gfba_cmd_type;

   typedef struct packed {
      logic init_done;
      logic func;
      logic run_zero;
      logic range_bad;
      logic occ_bit;
      logic cnt_zero;
      logic cnt_one;
      logic cnt_full;
      logic copy_last;
      logic load_done;
      logic res_last;
      logic out_free;
   } gfba_stat_type;

endpackage
`default_nettype wire

// File: src/gfba_req_if.sv
`default_nettype none
interface gfba_req_if import gfba_pkg::*;;
   logic               valid;
   logic               ready;
   logic               func;
   logic [COUNT_W-1:0] count;
   logic [BLOCK_W-1:0] block;

   modport source (output valid, func, count, block, input ready);
   modport sink   (input valid, func, count, block, output ready);
endinterface
`default_nettype wire

// File: src/gfba_rsp_if.sv
`default_nettype none
interface gfba_rsp_if import gfba_pkg::*;;
   logic                valid;
   logic                ready;
   logic [BLOCK_W-1:0]  block_out;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, block_out, status, last, input ready);
   modport sink   (input valid, block_out, status, last, output ready);
endinterface
`default_nettype wire

// File: src/grouped_free_block_allocator.sv
`default_nettype none
// Grouped free-list block allocator. A request either allocates a run of
// count blocks, clamped to MAX_RUN (one result per block, last set on the
// final one, or a single out-of-space result that ends the run; a count of
// zero gives no result) or releases one block (one result, status 1 if the
// block was not in use or is out of range). After reset the block runs a
// build pass that writes the link store and clears the in-use map, one
// word per cycle, with req ready low throughout. An allocate that hands out
// a group leader reads its list back from the link store, one word per
// cycle through the single RAM read port; a release writes the cached group
// into the released block's link entry when the cache is empty or full. A
// result waiting in the output register does not hold back the next request;
// rsp back-pressure stalls the next result in the emit state, and req ready
// stays low while it waits.
module grouped_free_block_allocator import gfba_pkg::*; #(
   parameter int GROUP_SIZE   = DEF_GROUP_SIZE,
   parameter int TOTAL_BLOCKS = DEF_TOTAL_BLOCKS,
   parameter int MAX_RUN      = DEF_MAX_RUN
) (
   input wire logic clock,
   input wire logic reset,
   gfba_req_if.sink   req_chan,
   gfba_rsp_if.source rsp_chan
);

   gfba_cmd_type  cmd;
   gfba_stat_type stat;

   // sequencer: one item at a time
   gfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   // cached group, link store RAM, in-use map and result registers
   gfba_dp #(
      .GROUP_SIZE   (GROUP_SIZE),
      .TOTAL_BLOCKS (TOTAL_BLOCKS),
      .MAX_RUN      (MAX_RUN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_func    (req_chan.func),
      .in_count   (req_chan.count),
      .in_block   (req_chan.block),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_block  (rsp_chan.block_out),
      .out_status (rsp_chan.status),
      .out_last   (rsp_chan.last)
   );

endmodule
`default_nettype wire

// File: src/gfba_dp.sv
`default_nettype none
module gfba_dp import gfba_pkg::*; #(
   parameter int GROUP_SIZE   = DEF_GROUP_SIZE,
   parameter int TOTAL_BLOCKS = DEF_TOTAL_BLOCKS,
   parameter int MAX_RUN      = DEF_MAX_RUN
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gfba_cmd_type        cmd,
   output gfba_stat_type            stat,
   input  wire logic                in_func,
   input  wire logic [COUNT_W-1:0]  in_count,
   input  wire logic [BLOCK_W-1:0]  in_block,
   input  wire logic                out_ready,
   output logic                     out_valid,
   output logic [BLOCK_W-1:0]       out_block,
   output logic [STATUS_W-1:0]      out_status,
   output logic                     out_last
);

   localparam int WORDS   = GROUP_SIZE + 1;
   localparam int BW      = $clog2(TOTAL_BLOCKS);
   localparam int IW      = $clog2(WORDS);
   localparam int XW      = $clog2(WORDS + 1);
   localparam int WW      = (BW > IW) ? BW : IW;
   localparam int LDEPTH  = TOTAL_BLOCKS * WORDS;
   localparam int LA      = $clog2(LDEPTH);
   localparam int RW      = $clog2(MAX_RUN + 1);
   localparam int PW      = $clog2(GROUP_SIZE);
   localparam int CNT_RST = (TOTAL_BLOCKS - 1 < GROUP_SIZE) ? TOTAL_BLOCKS - 1 : GROUP_SIZE;

   logic                func_ff;
   logic                rel_bad_ff;
   logic [BW-1:0]       blk_ff;
   logic [RW-1:0]       run_ff;

   logic [BW-1:0]       cache_mem [WORDS];
   logic [IW-1:0]       cnt_ff;
   logic [IW-1:0]       cache_ix;
   logic [BW-1:0]       cache_rd;

   logic [LA-1:0]       base_ff;
   logic [XW-1:0]       idx_ff;
   logic                ld_v_ff;
   logic [IW-1:0]       ld_i_ff;
   logic                issue;

   logic [LA-1:0]       ia_ff;
   logic [BW-1:0]       row_ff;
   logic [IW-1:0]       wd_ff;
   logic [PW-1:0]       ph_ff;
   logic                init_done_ff;
   logic [WW-1:0]       init_val;

   logic                occ_mem [TOTAL_BLOCKS];
   logic                occ_q_ff;
   logic                occ_we;
   logic [BW-1:0]       occ_wa;
   logic                occ_wd;

   logic [WW-1:0]       link_mem [LDEPTH];
   logic [WW-1:0]       lk_q_ff;
   logic                lk_we;
   logic [LA-1:0]       lk_wa;
   logic [LA-1:0]       lk_ra;
   logic [WW-1:0]       lk_wd;

   logic [BW-1:0]       res_blk_ff;
   logic [STATUS_W-1:0] res_st_ff;
   logic                res_last_ff;
   logic [BW-1:0]       out_blk_ff;

   assign cache_ix = cmd.copy_step ? idx_ff[IW-1:0] : cnt_ff;
   assign cache_rd = cache_mem[cache_ix];
   assign issue    = cmd.load_step && (idx_ff <= XW'(GROUP_SIZE));

   // reset image of the link store, one word per sweep step
   always_comb begin
      int r_i, s_i, n_i, w_i;
      r_i = int'(row_ff);
      s_i = r_i + GROUP_SIZE;
      w_i = int'(wd_ff);
      n_i = 0;
      if (s_i <= TOTAL_BLOCKS - 1) begin
         n_i = (TOTAL_BLOCKS - s_i > GROUP_SIZE) ? GROUP_SIZE : TOTAL_BLOCKS - s_i;
      end
      init_val = '0;
      if (ph_ff == PW'(1)) begin
         if (w_i == 0) begin
            init_val = WW'(n_i);
         end else if (w_i <= n_i) begin
            init_val = WW'(s_i + w_i - 1);
         end
      end
   end

   always_comb begin
      lk_ra = base_ff + LA'(idx_ff);
      if (!init_done_ff) begin
         lk_we = cmd.init_step;
         lk_wa = ia_ff;
         lk_wd = init_val;
      end else begin
         lk_we = cmd.copy_step;
         lk_wa = lk_ra;
         lk_wd = (idx_ff == '0) ? WW'(cnt_ff) : WW'(cache_rd);
      end
   end

   always_comb begin
      occ_we = 1'b0;
      occ_wa = blk_ff;
      occ_wd = 1'b0;
      if (cmd.init_step && wd_ff == '0) begin
         occ_we = 1'b1;
         occ_wa = row_ff;
      end else if (cmd.rel_free) begin
         occ_we = 1'b1;
      end else if (cmd.pop) begin
         occ_we = 1'b1;
         occ_wa = cache_rd;
         occ_wd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_wa] <= lk_wd;
      end
      lk_q_ff <= link_mem[lk_ra];
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_wa] <= occ_wd;
      end
      occ_q_ff <= occ_mem[blk_ff];
   end

   // reset sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         ia_ff        <= '0;
         row_ff       <= '0;
         wd_ff        <= '0;
         ph_ff        <= '0;
         init_done_ff <= 1'b0;
      end else if (cmd.init_step) begin
         ia_ff <= ia_ff + LA'(1);
         if (wd_ff == IW'(GROUP_SIZE)) begin
            wd_ff  <= '0;
            row_ff <= row_ff + BW'(1);
            ph_ff  <= (ph_ff == PW'(GROUP_SIZE - 1)) ? '0 : ph_ff + PW'(1);
            if (row_ff == BW'(TOTAL_BLOCKS - 1)) begin
               init_done_ff <= 1'b1;
            end
         end else begin
            wd_ff <= wd_ff + IW'(1);
         end
      end
   end

   // latched request
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         func_ff    <= in_func;
         rel_bad_ff <= (32'(in_block) >= TOTAL_BLOCKS);
         blk_ff     <= BW'(in_block);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (cmd.take) begin
         run_ff <= (32'(in_count) > MAX_RUN) ? RW'(MAX_RUN) : RW'(in_count);
      end else if (cmd.pop) begin
         run_ff <= run_ff - RW'(1);
      end
   end

   // word counter for copy and reload
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         ld_v_ff <= 1'b0;
         ld_i_ff <= '0;
      end else begin
         if (cmd.base_ld) begin
            idx_ff <= '0;
         end else if (cmd.copy_step || issue) begin
            idx_ff <= idx_ff + XW'(1);
         end
         ld_v_ff <= issue;
         ld_i_ff <= idx_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.base_ld) begin
         base_ff <= LA'(cmd.base_src ? cache_rd : blk_ff) * LA'(WORDS);
      end
   end

   // cached group
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= IW'(CNT_RST);
         for (int i = 0; i < WORDS; i++) begin
            cache_mem[i] <= (i >= 1 && i <= CNT_RST) ? BW'(i) : '0;
         end
      end else if (ld_v_ff) begin
         if (ld_i_ff == '0) begin
            cnt_ff <= (32'(lk_q_ff) > GROUP_SIZE) ? IW'(GROUP_SIZE) : IW'(lk_q_ff);
         end else begin
            cache_mem[ld_i_ff] <= BW'(lk_q_ff);
         end
      end else if (cmd.copy_fin) begin
         cnt_ff       <= IW'(1);
         cache_mem[1] <= blk_ff;
      end else if (cmd.rel_push) begin
         cnt_ff                     <= cnt_ff + IW'(1);
         cache_mem[cnt_ff + IW'(1)] <= blk_ff;
      end else if (cmd.pop && cnt_ff != IW'(1)) begin
         cnt_ff <= cnt_ff - IW'(1);
      end
   end

   // pending result and output register
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         res_blk_ff  <= cache_rd;
         res_st_ff   <= ST_OK;
         res_last_ff <= (run_ff == RW'(1));
      end else if (cmd.res_ld) begin
         res_blk_ff  <= '0;
         res_st_ff   <= cmd.res_status;
         res_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (cmd.emit) begin
         out_valid <= 1'b1;
      end else if (out_ready) begin
         out_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_blk_ff <= res_blk_ff;
         out_status <= res_st_ff;
         out_last   <= res_last_ff;
      end
   end

   assign out_block = BLOCK_W'(out_blk_ff);

   always_comb begin
      stat.init_done = init_done_ff;
      stat.func      = func_ff;
      stat.run_zero  = (run_ff == '0);
      stat.range_bad = rel_bad_ff;
      stat.occ_bit   = occ_q_ff;
      stat.cnt_zero  = (cnt_ff == '0);
      stat.cnt_one   = (cnt_ff == IW'(1));
      stat.cnt_full  = (cnt_ff >= IW'(GROUP_SIZE));
      stat.copy_last = (idx_ff == XW'(GROUP_SIZE));
      stat.load_done = ld_v_ff && (ld_i_ff == IW'(GROUP_SIZE));
      stat.res_last  = res_last_ff;
      stat.out_free  = !out_valid || out_ready;
   end

endmodule
`default_nettype wire

// File: src/gfba_ctrl.sv
`default_nettype none
module gfba_ctrl import gfba_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire gfba_stat_type stat,
   input  wire logic          req_valid,
   output logic               req_ready,
   output gfba_cmd_type       cmd
);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DISP  = 3'd2;
   localparam logic [2:0] S_RDEC  = 3'd3;
   localparam logic [2:0] S_COPY  = 3'd4;
   localparam logic [2:0] S_ALLOC = 3'd5;
   localparam logic [2:0] S_LOAD  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = !stat.init_done;
            if (stat.init_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.func == FUNC_RELEASE) begin
               state_in = S_RDEC;
            end else if (stat.run_zero) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_ALLOC;
            end
         end
         S_RDEC: begin
            if (stat.range_bad || !stat.occ_bit) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_NOT_OCC;
               state_in       = S_EMIT;
            end else begin
               cmd.rel_free = 1'b1;
               if (stat.cnt_zero || stat.cnt_full) begin
                  cmd.base_ld = 1'b1;
                  state_in    = S_COPY;
               end else begin
                  cmd.rel_push   = 1'b1;
                  cmd.res_ld     = 1'b1;
                  cmd.res_status = ST_OK;
                  state_in       = S_EMIT;
               end
            end
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (stat.copy_last) begin
               cmd.copy_fin   = 1'b1;
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_EMIT;
            end
         end
         S_ALLOC: begin
            if (stat.cnt_zero) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_NO_SPACE;
               state_in       = S_EMIT;
            end else begin
               cmd.pop = 1'b1;
               if (stat.cnt_one) begin
                  cmd.base_ld  = 1'b1;
                  cmd.base_src = 1'b1;
                  state_in     = S_LOAD;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_LOAD: begin
            cmd.load_step = 1'b1;
            if (stat.load_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.res_last ? S_IDLE : S_ALLOC;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: verif/tb_grouped_free_block_allocator.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_grouped_free_block_allocator;
   import gfba_pkg::*;

   localparam int GROUP = DEF_GROUP_SIZE;
   localparam int NBLK  = DEF_TOTAL_BLOCKS;
   localparam int RUN   = DEF_MAX_RUN;
   // Build pass plus ~430 items at their worst, several times over
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [BLOCK_W-1:0]  blk;
      logic [STATUS_W-1:0] status;
      logic                last;
   } grant_type;

   // Free-list mirror: cached group, link words, in-use map, and the
   // queue of grants still owed by the block.
   class free_list_board;
      logic [BLOCK_W-1:0] cache [GROUP+1];
      logic [BLOCK_W-1:0] links [NBLK][GROUP+1];
      bit                 in_use [NBLK];
      grant_type          owed [$];
      int                 errors;

      function new();
         int s, n;
         errors = 0;
         foreach (in_use[i]) in_use[i] = 0;
         foreach (links[i, j]) links[i][j] = '0;
         foreach (cache[i]) cache[i] = '0;
         cache[0] = BLOCK_W'(GROUP);
         for (int i = 1; i <= GROUP; i++) cache[i] = BLOCK_W'(i);
         for (int lead = 1; lead <= NBLK - 1; lead += GROUP) begin
            s = lead + GROUP;
            n = (s <= NBLK - 1) ? NBLK - s : 0;
            if (n > GROUP) n = GROUP;
            links[lead][0] = BLOCK_W'(n);
            for (int i = 1; i <= n; i++) links[lead][i] = BLOCK_W'(s + i - 1);
         end
      endfunction

      function int cached();
         return (cache[0] > GROUP) ? GROUP : int'(cache[0]);
      endfunction

      // Work out the grants caused by one accepted request item
      function void note_request(logic func, logic [COUNT_W-1:0] cnt,
                                 logic [BLOCK_W-1:0] blk);
         int n, c, got;
         logic [BLOCK_W-1:0] b;
         if (func == FUNC_ALLOC) begin
            n = (cnt > RUN) ? RUN : int'(cnt);
            got = 0;
            while (got < n) begin
               c = cached();
               if (c == 0) begin
                  owed.push_back('{'0, ST_NO_SPACE, 1'b1});
                  return;
               end
               if (c > 1) begin
                  b = cache[c];
                  cache[0] = BLOCK_W'(c - 1);
               end else begin
                  b = cache[1];
                  cache = links[b];
                  if (cache[0] > GROUP) cache[0] = BLOCK_W'(GROUP);
               end
               in_use[b] = 1;
               owed.push_back('{b, ST_OK, 1'b0});
               got++;
            end
            if (got > 0) owed[$].last = 1'b1;
         end else if (!in_use[blk]) begin
            owed.push_back('{'0, ST_NOT_OCC, 1'b1});
         end else begin
            in_use[blk] = 0;
            c = cached();
            if (c == 0 || c >= GROUP) begin
               cache[0] = BLOCK_W'(c);
               links[blk] = cache;
               cache[0] = BLOCK_W'(1);
               cache[1] = blk;
            end else begin
               cache[0] = BLOCK_W'(c + 1);
               cache[c+1] = blk;
            end
            owed.push_back('{'0, ST_OK, 1'b1});
         end
      endfunction

      function void check_grant(grant_type got);
         grant_type want;
         if (owed.size() == 0) begin
            $error("unexpected result: block_out %0d status %0d last %0d",
                   got.blk, got.status, got.last);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.blk !== want.blk) begin
            $error("block_out: expected %0d, got %0d", want.blk, got.blk);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction

      // Mostly an in-use block, so releases actually feed the free list
      function logic [BLOCK_W-1:0] some_used_block();
         int start;
         start = $urandom_range(0, NBLK - 1);
         for (int i = 0; i < NBLK; i++)
            if (in_use[(start + i) % NBLK]) return BLOCK_W'((start + i) % NBLK);
         return BLOCK_W'(start);
      endfunction
   endclass

   logic clock;
   logic reset;
   gfba_req_if req_chan ();
   gfba_rsp_if rsp_chan ();
   free_list_board board;
   int  accepted;
   bit  hold_done;

   grouped_free_block_allocator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one request item; returns after the edge that accepts it
   task automatic send_request(logic func, logic [COUNT_W-1:0] cnt,
                               logic [BLOCK_W-1:0] blk);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.func  <= func;
      req_chan.count <= cnt;
      req_chan.block <= blk;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(func, cnt, blk);
      accepted++;
   endtask

   task automatic alloc_run(int cnt);
      send_request(FUNC_ALLOC, COUNT_W'(cnt), BLOCK_W'($urandom));
   endtask

   task automatic release_block(int blk);
      send_request(FUNC_RELEASE, COUNT_W'($urandom), BLOCK_W'(blk));
   endtask

   // Result side: random stalls, plus one long hold-off partway through the
   // random part so the block backs up and drops req ready.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && accepted >= 200) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (600) @(negedge clock);
         end
         stall = $urandom_range(0, 3) == 0 ? gap_len() : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_grant('{rsp_chan.block_out, rsp_chan.status, rsp_chan.last});

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int r;
      board     = new();
      accepted  = 0;
      hold_done = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func  = FUNC_ALLOC;
      req_chan.count = '0;
      req_chan.block = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: edge values and the named corner cases
      release_block(0);           // block 0 is never in use
      release_block(NBLK - 1);    // free block, all-ones number
      alloc_run(0);               // zero count, no result
      alloc_run(1);               // takes block 16
      release_block(16);          // cache back to full
      alloc_run(31);              // oversized, clamped; leader 1 reloads cache
      release_block(5);           // release into full cache, spills
      release_block(5);           // now free again
      alloc_run(16);
      alloc_run(2);
      release_block(board.some_used_block());

      // Drain the whole list to reach out of space, then refill an empty cache
      while (board.cached() > 0)
         alloc_run(16);
      alloc_run(16);
      alloc_run(3);
      alloc_run(1);
      for (int i = 0; i < 20; i++) release_block(board.some_used_block());

      // Random mix
      for (int i = 0; i < 330; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            alloc_run($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                : $urandom_range(1, 8));
         else if (r < 88)
            release_block(board.some_used_block());
         else
            release_block($urandom_range(0, NBLK - 1));
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
src/gfba_pkg.sv
src/gfba_req_if.sv
src/gfba_rsp_if.sv
src/gfba_dp.sv
src/gfba_ctrl.sv
src/grouped_free_block_allocator.sv
verif/tb_grouped_free_block_allocator.sv
